/* rtl/hndf_pkg.sv */
// Shared types, constants and the bit-count function of the near-duplicate filter.
// Used by hndf_cell, hndf_chain and hamming_near_duplicate_filter; depends on nothing.
`default_nettype none

package hndf_pkg;

    localparam int HASH_W                 = 64;
    localparam int THR_W                  = 7;
    localparam int POP_W                  = 7;
    localparam int MATCH_INDEX_W          = 8;
    localparam int STORED_COUNT_W         = 9;
    localparam int STORE_CAPACITY_DEFAULT = 256;
    localparam int S_TDATA_W              = 64;
    localparam int M_TDATA_W              = 24;

    localparam logic [THR_W-1:0] THR_RESET = 7'd4;

    // Control bits that travel with a query from cell to cell.
    typedef struct packed {
        logic valid;
        logic found;
        logic stored;
    } token_ctrl_t;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_BUSY
    } filter_state_t;

    // Number of set bits in a hash word; synthesis builds an adder tree.
    function automatic logic [POP_W-1:0] bit_count(input logic [HASH_W-1:0] v);
        logic [POP_W-1:0] n;
        n = '0;
        for (int i = 0; i < HASH_W; i++) begin
            n = n + POP_W'(v[i]);
        end
        return n;
    endfunction

endpackage

`default_nettype wire

/* rtl/hndf_cell.sv */
// One cell of the filter chain: holds one stored hash and compares the passing query.
// Depends on hndf_pkg.
`default_nettype none

module hndf_cell #(
    parameter int IDX_W      = 8,
    parameter int CNT_W      = 9,
    parameter int CELL_INDEX = 0
) (
    input  wire                               aclk,
    input  wire                               aresetn,
    input  wire  [hndf_pkg::THR_W-1:0]        threshold,
    input  hndf_pkg::token_ctrl_t             in_ctrl,
    input  wire  [hndf_pkg::HASH_W-1:0]       in_hash,
    input  wire  [IDX_W-1:0]                  in_match,
    input  wire  [CNT_W-1:0]                  in_count,
    output hndf_pkg::token_ctrl_t             out_ctrl,
    output logic [hndf_pkg::HASH_W-1:0]       out_hash,
    output logic [IDX_W-1:0]                  out_match,
    output logic [CNT_W-1:0]                  out_count
);

    localparam logic [CNT_W-1:0] MY_POS = CNT_W'(CELL_INDEX);

    logic [hndf_pkg::HASH_W-1:0] entry_reg;
    hndf_pkg::token_ctrl_t       ctrl_reg, ctrl_next;
    logic [hndf_pkg::HASH_W-1:0] hash_reg;
    logic [IDX_W-1:0]            match_reg, match_next;
    logic [CNT_W-1:0]            count_reg;

    logic active, hit, write_here;
    logic [hndf_pkg::POP_W-1:0] distance;

    // Only entries below the fill count have been written, so only they are compared.
    // The first free entry sits exactly at the fill count.
    always_comb begin
        active     = in_ctrl.valid && (MY_POS < in_count);
        distance   = hndf_pkg::bit_count(entry_reg ^ in_hash);
        hit        = active && !in_ctrl.found && (distance < threshold);
        write_here = in_ctrl.valid && !in_ctrl.found && (in_count == MY_POS);

        ctrl_next.valid  = in_ctrl.valid;
        ctrl_next.found  = in_ctrl.found | hit;
        ctrl_next.stored = in_ctrl.stored | write_here;
        match_next       = hit ? IDX_W'(CELL_INDEX) : in_match;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_reg <= '0;
        end else begin
            ctrl_reg <= ctrl_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (write_here) begin
            entry_reg <= in_hash;
        end
        hash_reg  <= in_hash;
        match_reg <= match_next;
        count_reg <= in_count;
    end

    assign out_ctrl  = ctrl_reg;
    assign out_hash  = hash_reg;
    assign out_match = match_reg;
    assign out_count = count_reg;

endmodule

`default_nettype wire

/* rtl/hndf_chain.sv */
// Row of filter cells, one per store entry, each passing the query to the next.
// Depends on hndf_pkg and hndf_cell.
`default_nettype none

module hndf_chain #(
    parameter int STORE_CAPACITY = hndf_pkg::STORE_CAPACITY_DEFAULT,
    parameter int IDX_W          = 8,
    parameter int CNT_W          = 9
) (
    input  wire                               aclk,
    input  wire                               aresetn,
    input  wire  [hndf_pkg::THR_W-1:0]        threshold,
    input  hndf_pkg::token_ctrl_t             head_ctrl,
    input  wire  [hndf_pkg::HASH_W-1:0]       head_hash,
    input  wire  [IDX_W-1:0]                  head_match,
    input  wire  [CNT_W-1:0]                  head_count,
    output hndf_pkg::token_ctrl_t             tail_ctrl,
    output logic [IDX_W-1:0]                  tail_match,
    output logic [CNT_W-1:0]                  tail_count
);

    hndf_pkg::token_ctrl_t       ctrl_w  [0:STORE_CAPACITY];
    logic [hndf_pkg::HASH_W-1:0] hash_w  [0:STORE_CAPACITY];
    logic [IDX_W-1:0]            match_w [0:STORE_CAPACITY];
    logic [CNT_W-1:0]            count_w [0:STORE_CAPACITY];

    assign ctrl_w[0]  = head_ctrl;
    assign hash_w[0]  = head_hash;
    assign match_w[0] = head_match;
    assign count_w[0] = head_count;

    for (genvar i = 0; i < STORE_CAPACITY; i++) begin : g_cell
        hndf_cell #(
            .IDX_W      (IDX_W),
            .CNT_W      (CNT_W),
            .CELL_INDEX (i)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .threshold (threshold),
            .in_ctrl   (ctrl_w[i]),
            .in_hash   (hash_w[i]),
            .in_match  (match_w[i]),
            .in_count  (count_w[i]),
            .out_ctrl  (ctrl_w[i+1]),
            .out_hash  (hash_w[i+1]),
            .out_match (match_w[i+1]),
            .out_count (count_w[i+1])
        );
    end

    assign tail_ctrl  = ctrl_w[STORE_CAPACITY];
    assign tail_match = match_w[STORE_CAPACITY];
    assign tail_count = count_w[STORE_CAPACITY];

endmodule

`default_nettype wire

/* rtl/hamming_near_duplicate_filter.sv */
// Top level of the Hamming-distance near-duplicate filter: handshakes, fill count,
// threshold register and result register. Depends on hndf_pkg and hndf_chain.
//
//  channel  | direction | word contents (lowest bit first)
//  ---------+-----------+------------------------------------------------------
//  s_       | in        | tdata: image_hash[63:0]
//  m_       | out       | tuser: is_new; tdata: match_index, stored_count, store_full
//  cfg_     | in        | wdata: distance_threshold[6:0], written when cfg_we is high
//
// One word is in the chain at a time. It walks one cell per cycle, and the result
// register takes it from the last cell. The next word is taken once the chain is empty
// and the result register is free or being read, so a new word is never accepted while
// one is still in the chain. Reset empties the store at once (fill count to zero) and
// sets the threshold to 4; a stall on m_ holds the result and keeps s_tready low.
`default_nettype none

module hamming_near_duplicate_filter #(
    parameter int STORE_CAPACITY = hndf_pkg::STORE_CAPACITY_DEFAULT
) (
    input  wire                                aclk,
    input  wire                                aresetn,
    input  wire                                s_tvalid,
    output logic                               s_tready,
    input  wire  [hndf_pkg::S_TDATA_W-1:0]     s_tdata,   // image_hash[63:0]
    output logic                               m_tvalid,
    input  wire                                m_tready,
    output logic [hndf_pkg::M_TDATA_W-1:0]     m_tdata,   // match_index[7:0],
                                                          // stored_count[16:8],
                                                          // store_full[17], zero[23:18]
    output logic                               m_tuser,   // is_new
    input  wire                                cfg_we,
    input  wire  [hndf_pkg::THR_W-1:0]         cfg_wdata  // distance_threshold[6:0]
);

    localparam int IDX_W = (STORE_CAPACITY > 1) ? $clog2(STORE_CAPACITY) : 1;
    localparam int CNT_W = $clog2(STORE_CAPACITY + 1);
    localparam int MI_W  = hndf_pkg::MATCH_INDEX_W;
    localparam int SC_W  = hndf_pkg::STORED_COUNT_W;
    localparam int PAD_W = hndf_pkg::M_TDATA_W - MI_W - SC_W - 1;

    hndf_pkg::filter_state_t state_reg, state_next;

    logic [hndf_pkg::THR_W-1:0] threshold_reg;
    logic [CNT_W-1:0]           entry_count_reg, entry_count_next;

    logic             out_valid_reg, out_valid_next;
    logic             out_new_reg;
    logic [MI_W-1:0]  out_match_reg;
    logic [SC_W-1:0]  out_count_reg;
    logic             out_full_reg;

    logic                  in_accept;
    hndf_pkg::token_ctrl_t head_ctrl, tail_ctrl;
    logic [IDX_W-1:0]      tail_match;
    logic [CNT_W-1:0]      tail_count;
    logic [CNT_W-1:0]      new_count;

    logic [IDX_W+MI_W-1:0] match_ext;
    logic [CNT_W+SC_W-1:0] count_ext;

    hndf_chain #(
        .STORE_CAPACITY (STORE_CAPACITY),
        .IDX_W          (IDX_W),
        .CNT_W          (CNT_W)
    ) u_chain (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .threshold  (threshold_reg),
        .head_ctrl  (head_ctrl),
        .head_hash  (s_tdata),
        .head_match ('0),
        .head_count (entry_count_reg),
        .tail_ctrl  (tail_ctrl),
        .tail_match (tail_match),
        .tail_count (tail_count)
    );

    assign new_count = tail_count + CNT_W'(tail_ctrl.stored);
    // Wide parameters keep only the low bits of the index and the count.
    assign match_ext = {{MI_W{1'b0}}, tail_match};
    assign count_ext = {{SC_W{1'b0}}, new_count};

    always_comb begin
        state_next       = state_reg;
        s_tready         = 1'b0;
        entry_count_next = entry_count_reg;
        out_valid_next   = out_valid_reg && !m_tready;

        case (state_reg)
            hndf_pkg::ST_IDLE: begin
                s_tready = !out_valid_reg || m_tready;
                if (s_tvalid && s_tready) begin
                    state_next = hndf_pkg::ST_BUSY;
                end
            end
            hndf_pkg::ST_BUSY: begin
                if (tail_ctrl.valid) begin
                    state_next       = hndf_pkg::ST_IDLE;
                    entry_count_next = new_count;
                    out_valid_next   = 1'b1;
                end
            end
            default: begin
                state_next = hndf_pkg::ST_IDLE;
            end
        endcase

        in_accept        = s_tvalid && s_tready;
        head_ctrl.valid  = in_accept;
        head_ctrl.found  = 1'b0;
        head_ctrl.stored = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= hndf_pkg::ST_IDLE;
            threshold_reg   <= hndf_pkg::THR_RESET;
            entry_count_reg <= '0;
            out_valid_reg   <= 1'b0;
        end else begin
            state_reg       <= state_next;
            entry_count_reg <= entry_count_next;
            out_valid_reg   <= out_valid_next;
            if (cfg_we) begin
                threshold_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == hndf_pkg::ST_BUSY && tail_ctrl.valid) begin
            out_new_reg   <= !tail_ctrl.found;
            out_match_reg <= match_ext[MI_W-1:0];
            out_count_reg <= count_ext[SC_W-1:0];
            out_full_reg  <= !tail_ctrl.found && !tail_ctrl.stored;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_new_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, out_full_reg, out_count_reg, out_match_reg};

endmodule

`default_nettype wire

/* test/tb_hamming_near_duplicate_filter.sv */
// Self-checking testbench for hamming_near_duplicate_filter: directed and random hash words
// under several distance thresholds, checked against an in-bench model of the hash store.
// Depends on hndf_pkg and the filter RTL only.
`timescale 1ns / 100ps

module tb_hamming_near_duplicate_filter;

    localparam int CAPACITY = hndf_pkg::STORE_CAPACITY_DEFAULT;
    localparam int SETTLE   = 4;

    typedef enum logic [1:0] {
        JOB_HASH,
        JOB_THRESHOLD,
        JOB_DRAIN
    } job_kind_t;

    typedef struct {
        job_kind_t   kind;
        logic [63:0] value;
    } job_t;

    typedef struct packed {
        logic       is_new;
        logic [7:0] match_index;
        logic [8:0] stored_count;
        logic       store_full;
    } verdict_t;

    logic                              aclk      = 1'b0;
    logic                              aresetn   = 1'b0;
    logic                              s_tvalid  = 1'b0;
    wire                               s_tready;
    logic [hndf_pkg::S_TDATA_W-1:0]    s_tdata   = '0;
    wire                               m_tvalid;
    logic                              m_tready  = 1'b0;
    wire  [hndf_pkg::M_TDATA_W-1:0]    m_tdata;
    wire                               m_tuser;
    logic                              cfg_we    = 1'b0;
    logic [hndf_pkg::THR_W-1:0]        cfg_wdata = '0;

    job_t        job_queue[$];
    verdict_t    verdict_queue[$];
    logic [63:0] sent_hashes[$];

    // Model of the store and the threshold register.
    logic [63:0]                kept_hashes [CAPACITY];
    int unsigned                kept_count      = 0;
    logic [hndf_pkg::THR_W-1:0] model_threshold = hndf_pkg::THR_RESET;

    int unsigned error_count  = 0;
    int unsigned gap_left     = 0;
    int unsigned stall_left   = 0;
    int unsigned quiet_cycles = 0;
    int unsigned launched     = 0;
    logic        idle_allowed = 1'b0;
    logic        drv_valid;
    logic        drv_we;
    verdict_t    want;

    hamming_near_duplicate_filter uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Walks the kept hashes in order and appends the word when nothing is close enough and the store has room.
    function automatic verdict_t judge_hash(input logic [63:0] h);
        verdict_t    v;
        int unsigned i;
        v.is_new       = 1'b1;
        v.match_index  = '0;
        v.store_full   = 1'b0;
        for (i = 0; i < kept_count && v.is_new; i++) begin
            if ($countones(kept_hashes[i] ^ h) < int'(model_threshold)) begin
                v.is_new      = 1'b0;
                v.match_index = 8'(i);
            end
        end
        if (v.is_new) begin
            if (kept_count < CAPACITY) begin
                kept_hashes[kept_count] = h;
                kept_count++;
            end else begin
                v.store_full = 1'b1;
            end
        end
        v.stored_count = 9'(kept_count);
        return v;
    endfunction

    task automatic add_hash(input logic [63:0] h);
        job_t j;
        j.kind  = JOB_HASH;
        j.value = h;
        job_queue.insert(job_queue.size(), j);
        sent_hashes.insert(sent_hashes.size(), h);
    endtask

    task automatic add_threshold(input int unsigned thr);
        job_t j;
        j.kind  = JOB_THRESHOLD;
        j.value = 64'(thr);
        job_queue.insert(job_queue.size(), j);
    endtask

    task automatic add_drain();
        job_t j;
        j.kind  = JOB_DRAIN;
        j.value = 64'd0;
        job_queue.insert(job_queue.size(), j);
    endtask

    // Mix of fresh hashes and near copies of earlier ones, the flip count straddling
    // the threshold so both outcomes show up.
    task automatic add_random_phase(input int unsigned thr, input int unsigned count);
        logic [63:0] h;
        int unsigned flips;
        int unsigned n;
        int unsigned bit_pos;
        add_threshold(thr);
        for (n = 0; n < count; n++) begin
            if (n == count / 2) begin
                add_drain();
            end
            if (sent_hashes.size() > 0 && $urandom_range(0, 99) < 45) begin
                h = sent_hashes[$urandom_range(0, sent_hashes.size() - 1)];
                flips = $urandom_range(0, (thr + 2 > 64) ? 64 : thr + 2);
                repeat (flips) begin
                    bit_pos = $urandom_range(0, 63);
                    h[bit_pos] = ~h[bit_pos];
                end
            end else begin
                h = {$urandom, $urandom};
                case ($urandom_range(0, 3))
                    0: h = h & {$urandom, $urandom};
                    1: h = h | {$urandom, $urandom};
                    default: ;
                endcase
            end
            add_hash(h);
        end
    endtask

    task automatic check_field(input string name, input longint unsigned exp_v,
                               input longint unsigned act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            error_count++;
        end
    endtask

    // Driver: one word or one register write per job; writes and drains wait for an empty pipe.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid     <= 1'b0;
            cfg_we       <= 1'b0;
            gap_left     = 0;
            quiet_cycles = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                verdict_queue.insert(verdict_queue.size(), judge_hash(s_tdata));
            end
            if (!s_tvalid && verdict_queue.size() == 0) begin
                quiet_cycles++;
            end else begin
                quiet_cycles = 0;
            end
            drv_valid = s_tvalid && !s_tready;
            drv_we    = 1'b0;
            if (!drv_valid) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (job_queue.size() != 0) begin
                    case (job_queue[0].kind)
                        JOB_HASH: begin
                            drv_valid = 1'b1;
                            s_tdata   <= job_queue[0].value;
                            void'(job_queue.pop_front());
                            launched++;
                            if (idle_allowed && $urandom_range(0, 2) == 0) begin
                                gap_left = $urandom_range(1, 3);
                            end
                        end
                        JOB_THRESHOLD: begin
                            if (quiet_cycles >= SETTLE) begin
                                drv_we          = 1'b1;
                                cfg_wdata       <= job_queue[0].value[hndf_pkg::THR_W-1:0];
                                model_threshold = job_queue[0].value[hndf_pkg::THR_W-1:0];
                                void'(job_queue.pop_front());
                            end
                        end
                        JOB_DRAIN: begin
                            if (quiet_cycles >= SETTLE) begin
                                void'(job_queue.pop_front());
                            end
                        end
                        default: ;
                    endcase
                end
            end
            s_tvalid     <= drv_valid;
            cfg_we       <= drv_we;
            // Idle-free stretch every 64 words, and none at all near the end.
            idle_allowed <= (job_queue.size() >= 80) && ((launched % 64) >= 16);
        end
    end

    // Monitor: compares each accepted result word with the oldest expectation.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready   <= 1'b0;
            stall_left = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (verdict_queue.size() == 0) begin
                    $error("result word with no expectation pending");
                    error_count++;
                end else begin
                    want = verdict_queue.pop_front();
                    check_field("is_new", want.is_new, m_tuser);
                    check_field("match_index", want.match_index, m_tdata[7:0]);
                    check_field("stored_count", want.stored_count, m_tdata[16:8]);
                    check_field("store_full", want.store_full, m_tdata[17]);
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (idle_allowed && $urandom_range(0, 3) == 0) begin
                stall_left = $urandom_range(0, 2);
                m_tready   <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        // Reset threshold of 4 first, without a write.
        add_hash(64'h0);
        add_hash(64'h7);
        add_hash(64'hF);
        add_hash(64'hFFFF_FFFF_FFFF_FFFF);
        add_hash(~64'h7);
        add_hash(64'h8000_0000_0000_0001);
        add_hash(64'hA5A5_5A5A_0FF0_F00F);
        add_drain();
        // A zero threshold stores even exact duplicates.
        add_threshold(0);
        add_hash(64'h0);
        add_hash(64'hFFFF_FFFF_FFFF_FFFF);
        add_threshold(1);
        add_hash(64'h0);
        add_hash(64'h1);
        // At 64 only a full complement escapes; above 64 everything hits entry zero.
        add_threshold(64);
        add_hash(64'hFFFF_FFFF_FFFF_FFFF);
        add_hash(64'h5555_5555_5555_5555);
        add_threshold(65);
        add_hash(64'hFFFF_FFFF_FFFF_FFFF);
        add_threshold(127);
        add_hash({$urandom, $urandom});

        // The store fills up during the later phases and stays full.
        add_random_phase(10, 150);
        add_random_phase(0, 40);
        add_random_phase(40, 60);
        add_random_phase(3, 150);
        add_random_phase(64, 30);
        add_random_phase(16, 170);

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        while (job_queue.size() != 0 || s_tvalid || verdict_queue.size() != 0) begin
            @(posedge aclk);
        end
        repeat (2 * CAPACITY) @(posedge aclk);
        if (error_count == 0 && verdict_queue.size() == 0) begin
            $display("tb_hamming_near_duplicate_filter: PASS");
        end else begin
            $display("tb_hamming_near_duplicate_filter: FAIL");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("tb_hamming_near_duplicate_filter: FAIL");
        $finish;
    end

endmodule
